/* rtl/core/pps_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Preemptive priority scheduler package
// Shared types, codes and the task ranking function of the scheduler.
// ----------------------------------------------------------------------------
package pps_pkg;

  // Default number of ready slots.
  localparam int QUEUE_DEPTH_DEF = 16;

  // Command codes of an input word.
  localparam logic CMD_ADD  = 1'b0;
  localparam logic CMD_TICK = 1'b1;

  localparam logic [15:0] WAIT_MAX  = 16'hFFFF;
  localparam logic [15:0] COUNT_MAX = 16'hFFFF;
  localparam logic [31:0] TOTAL_MAX = 32'hFFFF_FFFF;

  // One task record, as held in a slot or in the run register.
  typedef struct packed {
    logic [7:0]  id;
    logic [7:0]  prio;
    logic [15:0] arrival;
    logic [15:0] remaining;
    logic [15:0] wait_cnt;
    logic [15:0] burst;
  } task_rec_t;

  // Input word.
  typedef struct packed {
    logic        cmd;
    logic [7:0]  task_id;
    logic [15:0] burst_len;
    logic [7:0]  prio_level;
  } in_word_t;

  // Result word.
  typedef struct packed {
    logic        add_rejected;
    logic        ran_valid;
    logic [7:0]  ran_id;
    logic        done_res;
    logic [15:0] done_wait;
    logic [16:0] done_turnaround;
    logic [31:0] sum_wait;
    logic [31:0] sum_turnaround;
    logic [15:0] finished_count;
    logic [15:0] now_time;
  } out_word_t;

  // Token that travels down the cell chain, one cell per cycle.
  typedef struct packed {
    logic      active;
    logic      cmd;
    logic      claimed;
    logic      best_valid;
    task_rec_t best_rec;
  } link_t;

  // Update that the scheduler broadcasts to all cells at the end of a tick.
  typedef struct packed {
    logic en;
    logic preempt;
    logic take;
  } apply_t;

  typedef enum logic {
    ST_IDLE,
    ST_SCAN
  } state_t;

  // True when task a ranks strictly ahead of task b.
  function automatic logic ranks_ahead(input task_rec_t a, input task_rec_t b);
    logic za;
    logic zb;
    logic res;
    za = (a.remaining == 16'd0);
    zb = (b.remaining == 16'd0);
    if (za && !zb) begin
      res = 1'b0;
    end else if (zb && !za) begin
      res = 1'b1;
    end else if (a.prio != b.prio) begin
      res = (a.prio < b.prio);
    end else if (a.arrival != b.arrival) begin
      res = (a.arrival < b.arrival);
    end else begin
      res = (a.remaining < b.remaining);
    end
    return res;
  endfunction

endpackage

/* rtl/core/preemptive_priority_scheduler_unit.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Preemptive priority scheduler
// A word accepted at the head starts a token down the chain of slot cells; it
// passes the link register of every cell, and at the tail the result word is
// registered and marked by out_strobe, which the receiver cannot stall. No
// new word is taken until the token reaches the tail. Reset (rst_n low,
// synchronous) empties all slots, the run register and clears time and totals.
// ----------------------------------------------------------------------------
module preemptive_priority_scheduler_unit #(
  parameter int QUEUE_DEPTH = pps_pkg::QUEUE_DEPTH_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  output logic                busy,
  input  pps_pkg::in_word_t   in_word,
  output logic                out_strobe,
  output pps_pkg::out_word_t  out_word
);

  localparam int IDX_W = $clog2(QUEUE_DEPTH);

  pps_pkg::state_t     state_r;
  pps_pkg::state_t     state_nxt;
  pps_pkg::link_t      lnk [QUEUE_DEPTH+1];
  logic [IDX_W-1:0]    lnk_idx [QUEUE_DEPTH+1];
  logic                head_active_r;
  logic                head_cmd_r;
  pps_pkg::task_rec_t  add_rec_r;
  pps_pkg::task_rec_t  run_r;
  pps_pkg::task_rec_t  run_nxt;
  logic                run_valid_r;
  logic                run_valid_nxt;
  logic [15:0]         tick_r;
  logic [15:0]         tick_nxt;
  logic [31:0]         wait_total_r;
  logic [31:0]         wait_total_nxt;
  logic [31:0]         turn_total_r;
  logic [31:0]         turn_total_nxt;
  logic [15:0]         done_total_r;
  logic [15:0]         done_total_nxt;
  logic                out_strobe_r;
  pps_pkg::out_word_t  out_word_r;
  pps_pkg::out_word_t  out_word_nxt;
  pps_pkg::apply_t     apply;
  logic                accept;
  logic                fin;
  logic                tick_fin;
  pps_pkg::link_t      tail;
  pps_pkg::task_rec_t  cur;
  logic                cur_v;
  logic [15:0]         rem_dec;
  logic                done;
  logic [16:0]         dturn;
  logic [32:0]         wsum;
  logic [32:0]         tsum;

  assign accept   = start && !busy;
  assign tail     = lnk[QUEUE_DEPTH];
  assign fin      = (state_r == pps_pkg::ST_SCAN) && tail.active;
  assign tick_fin = fin && (tail.cmd == pps_pkg::CMD_TICK);

  // Head of the chain: the token starts here on the cycle after accept.
  assign lnk[0].active     = head_active_r;
  assign lnk[0].cmd        = head_cmd_r;
  assign lnk[0].claimed    = 1'b0;
  assign lnk[0].best_valid = 1'b0;
  assign lnk[0].best_rec   = add_rec_r;
  assign lnk_idx[0]        = '0;

  // Row of slot cells.
  for (genvar g = 0; g < QUEUE_DEPTH; g++) begin : g_cell
    pps_cell #(
      .IDX_W    (IDX_W),
      .CELL_IDX (g)
    ) u_cell (
      .clk         (clk),
      .rst_n       (rst_n),
      .lnk_i       (lnk[g]),
      .lnk_idx_i   (lnk_idx[g]),
      .lnk_o       (lnk[g+1]),
      .lnk_idx_o   (lnk_idx[g+1]),
      .add_rec_i   (add_rec_r),
      .apply_i     (apply),
      .apply_idx_i (lnk_idx[QUEUE_DEPTH]),
      .apply_rec_i (run_r)
    );
  end

  // Next state.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      pps_pkg::ST_IDLE: begin
        if (start) begin
          state_nxt = pps_pkg::ST_SCAN;
        end
      end
      pps_pkg::ST_SCAN: begin
        if (tail.active) begin
          state_nxt = pps_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = pps_pkg::ST_IDLE;
      end
    endcase
  end

  // State machine outputs.
  always_comb begin
    busy = 1'b0;
    unique case (state_r)
      pps_pkg::ST_IDLE: busy = 1'b0;
      pps_pkg::ST_SCAN: busy = 1'b1;
      default:          busy = 1'b0;
    endcase
  end

  // Decision at the end of a tick: preempt, fill an idle run slot, run a unit.
  always_comb begin
    apply.en      = tick_fin;
    apply.preempt = tail.best_valid && run_valid_r &&
                    (tail.best_rec.prio < run_r.prio) &&
                    pps_pkg::ranks_ahead(tail.best_rec, run_r);
    apply.take    = tail.best_valid && !run_valid_r;
    cur     = (apply.preempt || apply.take) ? tail.best_rec : run_r;
    cur_v   = run_valid_r || apply.take;
    rem_dec = cur.remaining - {15'd0, (cur.remaining != 16'd0)};
    done    = cur_v && (rem_dec == 16'd0);
    dturn   = {1'b0, cur.wait_cnt} + {1'b0, cur.burst};
    wsum    = {1'b0, wait_total_r} + {17'd0, cur.wait_cnt};
    tsum    = {1'b0, turn_total_r} + {16'd0, dturn};
  end

  // Next values of the run register, time and totals.
  always_comb begin
    run_nxt        = run_r;
    run_valid_nxt  = run_valid_r;
    tick_nxt       = tick_r;
    wait_total_nxt = wait_total_r;
    turn_total_nxt = turn_total_r;
    done_total_nxt = done_total_r;
    if (tick_fin) begin
      run_nxt           = cur;
      run_nxt.remaining = rem_dec;
      run_valid_nxt     = cur_v && !done;
      tick_nxt          = tick_r + 16'd1;
      if (done) begin
        wait_total_nxt = wsum[32] ? pps_pkg::TOTAL_MAX : wsum[31:0];
        turn_total_nxt = tsum[32] ? pps_pkg::TOTAL_MAX : tsum[31:0];
        if (done_total_r != pps_pkg::COUNT_MAX) begin
          done_total_nxt = done_total_r + 16'd1;
        end
      end
    end
  end

  // Result word.
  always_comb begin
    out_word_nxt                 = '0;
    out_word_nxt.add_rejected    = (tail.cmd == pps_pkg::CMD_ADD) && !tail.claimed;
    out_word_nxt.sum_wait        = wait_total_nxt;
    out_word_nxt.sum_turnaround  = turn_total_nxt;
    out_word_nxt.finished_count  = done_total_nxt;
    out_word_nxt.now_time        = tick_nxt;
    if (tick_fin) begin
      out_word_nxt.ran_valid = cur_v;
      out_word_nxt.ran_id    = cur_v ? cur.id : 8'd0;
      if (done) begin
        out_word_nxt.done_res        = 1'b1;
        out_word_nxt.done_wait       = cur.wait_cnt;
        out_word_nxt.done_turnaround = dturn;
      end
    end
  end

  // Control state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= pps_pkg::ST_IDLE;
      head_active_r <= 1'b0;
      run_valid_r   <= 1'b0;
      tick_r        <= '0;
      wait_total_r  <= '0;
      turn_total_r  <= '0;
      done_total_r  <= '0;
      out_strobe_r  <= 1'b0;
    end else begin
      state_r       <= state_nxt;
      head_active_r <= accept;
      run_valid_r   <= run_valid_nxt;
      tick_r        <= tick_nxt;
      wait_total_r  <= wait_total_nxt;
      turn_total_r  <= turn_total_nxt;
      done_total_r  <= done_total_nxt;
      out_strobe_r  <= fin;
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    run_r <= run_nxt;
    if (accept) begin
      head_cmd_r          <= in_word.cmd;
      add_rec_r.id        <= in_word.task_id;
      add_rec_r.prio      <= in_word.prio_level;
      add_rec_r.arrival   <= tick_r;
      add_rec_r.remaining <= in_word.burst_len;
      add_rec_r.wait_cnt  <= 16'd0;
      add_rec_r.burst     <= in_word.burst_len;
    end
    if (fin) begin
      out_word_r <= out_word_nxt;
    end
  end

  assign out_strobe = out_strobe_r;
  assign out_word   = out_word_r;

  // A result word follows the end of exactly one scan.
  a_strobe_after_fin: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe_r |-> $past(fin))
    else $error("result strobe without a finished scan");

  // The token reaches the tail only while a scan is in progress.
  a_tail_in_scan: assert property (@(posedge clk) disable iff (!rst_n)
    tail.active |-> (state_r == pps_pkg::ST_SCAN))
    else $error("token at chain tail outside of a scan");

  // A finished task leaves the run register.
  a_done_clears_run: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe_r && out_word_r.done_res) |-> !run_valid_r)
    else $error("run register still valid after completion");

  // A rejected add never reports a task run or a completion.
  a_add_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe_r && out_word_r.add_rejected) |->
      (!out_word_r.ran_valid && !out_word_r.done_res))
    else $error("add result carries run or completion data");

  // Time only moves at the end of a tick.
  a_time_on_tick: assert property (@(posedge clk) disable iff (!rst_n)
    !tick_fin |=> $stable(tick_r))
    else $error("tick counter moved outside a tick");

endmodule

/* rtl/core/pps_cell.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Scheduler slot cell
// Holds one ready slot. Passes the scan token to its neighbor each cycle,
// folding its own task into the running best or claiming itself for an add.
// ----------------------------------------------------------------------------
module pps_cell #(
  parameter int IDX_W    = 4,
  parameter int CELL_IDX = 0
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  pps_pkg::link_t       lnk_i,
  input  logic [IDX_W-1:0]     lnk_idx_i,
  output pps_pkg::link_t       lnk_o,
  output logic [IDX_W-1:0]     lnk_idx_o,
  input  pps_pkg::task_rec_t   add_rec_i,
  input  pps_pkg::apply_t      apply_i,
  input  logic [IDX_W-1:0]     apply_idx_i,
  input  pps_pkg::task_rec_t   apply_rec_i
);

  localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(CELL_IDX);

  logic                 valid_r;
  logic                 valid_nxt;
  pps_pkg::task_rec_t   rec_r;
  pps_pkg::task_rec_t   rec_nxt;
  pps_pkg::link_t       lnk_r;
  pps_pkg::link_t       lnk_nxt;
  logic [IDX_W-1:0]     lnk_idx_r;
  logic [IDX_W-1:0]     lnk_idx_nxt;
  logic                 sel;

  assign sel = (apply_idx_i == MY_IDX);

  // Token pass and slot update. A scan and a broadcast never meet in a cycle.
  always_comb begin
    lnk_nxt     = lnk_i;
    lnk_idx_nxt = lnk_idx_i;
    valid_nxt   = valid_r;
    rec_nxt     = rec_r;
    if (lnk_i.active) begin
      if (lnk_i.cmd == pps_pkg::CMD_TICK) begin
        // Ties keep the earlier slot, so only a strict win replaces it.
        if (valid_r && (!lnk_i.best_valid || pps_pkg::ranks_ahead(rec_r, lnk_i.best_rec))) begin
          lnk_nxt.best_valid = 1'b1;
          lnk_nxt.best_rec   = rec_r;
          lnk_idx_nxt        = MY_IDX;
        end
      end else if (!lnk_i.claimed && !valid_r) begin
        // The lowest free slot takes the new task.
        lnk_nxt.claimed = 1'b1;
        valid_nxt       = 1'b1;
        rec_nxt         = add_rec_i;
      end
    end
    if (apply_i.en) begin
      if (sel && apply_i.preempt) begin
        // The preempted task lands here and waits this tick as well.
        rec_nxt = apply_rec_i;
        if (apply_rec_i.wait_cnt != pps_pkg::WAIT_MAX) begin
          rec_nxt.wait_cnt = apply_rec_i.wait_cnt + 16'd1;
        end
      end else if (sel && apply_i.take) begin
        valid_nxt = 1'b0;
      end else if (valid_r && (rec_r.wait_cnt != pps_pkg::WAIT_MAX)) begin
        rec_nxt.wait_cnt = rec_r.wait_cnt + 16'd1;
      end
    end
  end

  // Control state and scan token.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      lnk_r   <= '0;
    end else begin
      valid_r <= valid_nxt;
      lnk_r   <= lnk_nxt;
    end
  end

  // Payload state.
  always_ff @(posedge clk) begin
    rec_r     <= rec_nxt;
    lnk_idx_r <= lnk_idx_nxt;
  end

  assign lnk_o     = lnk_r;
  assign lnk_idx_o = lnk_idx_r;

endmodule

/* bench/tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Preemptive priority scheduler testbench
// Sends add and tick words to the scheduler and predicts each result word
// from a behavioral copy of the ready table, the run slot, the tick counter
// and the completion totals. Every strobed result word is then checked field
// by field. Directed tests come first, followed by random traffic under
// three sender idling levels.
// ----------------------------------------------------------------------------
module tb;

  localparam int DEPTH        = pps_pkg::QUEUE_DEPTH_DEF;
  localparam int CYCLE_LIMIT  = 300000;
  localparam int DRAIN_CYCLES = DEPTH + 4;
  localparam int RANDOM_WORDS = 240;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               start = 1'b0;
  logic               busy;
  pps_pkg::in_word_t  in_word = '0;
  logic               out_strobe;
  pps_pkg::out_word_t out_word;

  preemptive_priority_scheduler_unit #(
    .QUEUE_DEPTH(DEPTH)
  ) u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_word   (in_word),
    .out_strobe(out_strobe),
    .out_word  (out_word)
  );

  always #10 clk = ~clk;

  // Behavioral copy of the scheduler state.
  pps_pkg::task_rec_t ready_rec [DEPTH];
  logic               ready_used [DEPTH];
  logic               run_active;
  pps_pkg::task_rec_t run_task;
  logic [15:0]        tick_now;
  logic [31:0]        wait_sum;
  logic [31:0]        turn_sum;
  logic [15:0]        tasks_finished;

  pps_pkg::out_word_t expected_results [$];

  int mismatches = 0;
  int cycle_count = 0;
  int sender_idle_pct = 0;
  int words_sent = 0;
  int ticks_sent = 0;
  int adds_sent = 0;
  int adds_rejected = 0;
  int preemptions = 0;

  task automatic clear_schedule_state();
    int i;
    for (i = 0; i < DEPTH; i++) begin
      ready_used[i] = 1'b0;
      ready_rec[i]  = '0;
    end
    run_active     = 1'b0;
    run_task       = '0;
    tick_now       = '0;
    wait_sum       = '0;
    turn_sum       = '0;
    tasks_finished = '0;
  endtask

  // A task that still needs time beats one that does not; after that the
  // lower priority value, the earlier arrival, then the shorter remainder.
  function automatic bit outranks(input pps_pkg::task_rec_t a, input pps_pkg::task_rec_t b);
    bit a_live;
    bit b_live;
    a_live = (a.remaining != 16'd0);
    b_live = (b.remaining != 16'd0);
    if (a_live != b_live) return a_live;
    if (a.prio != b.prio) return a.prio < b.prio;
    if (a.arrival != b.arrival) return a.arrival < b.arrival;
    return a.remaining < b.remaining;
  endfunction

  function automatic logic [31:0] add_clamped(input logic [31:0] a, input logic [31:0] b);
    logic [32:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[32] ? pps_pkg::TOTAL_MAX : s[31:0];
  endfunction

  // Apply one word to the state copy and return the result word it causes.
  function automatic pps_pkg::out_word_t schedule_step(input pps_pkg::in_word_t w);
    pps_pkg::out_word_t r;
    pps_pkg::task_rec_t cand;
    pps_pkg::task_rec_t fresh;
    int                 free_idx;
    int                 best;
    int                 i;
    r = '0;
    if (w.cmd == pps_pkg::CMD_ADD) begin
      adds_sent++;
      free_idx = -1;
      for (i = 0; i < DEPTH; i++) begin
        if (!ready_used[i] && free_idx < 0) free_idx = i;
      end
      if (free_idx < 0) begin
        r.add_rejected = 1'b1;
        adds_rejected++;
      end else begin
        fresh.id        = w.task_id;
        fresh.prio      = w.prio_level;
        fresh.arrival   = tick_now;
        fresh.remaining = w.burst_len;
        fresh.wait_cnt  = 16'd0;
        fresh.burst     = w.burst_len;
        ready_rec[free_idx]  = fresh;
        ready_used[free_idx] = 1'b1;
      end
    end else begin
      ticks_sent++;
      // Pick the best ready task; full ties keep the lowest slot.
      best = -1;
      for (i = 0; i < DEPTH; i++) begin
        if (ready_used[i] && (best < 0 || outranks(ready_rec[i], ready_rec[best]))) best = i;
      end
      if (best >= 0) begin
        cand = ready_rec[best];
        if (run_active) begin
          // The displaced task takes over the slot of the one that preempts it.
          if (cand.prio < run_task.prio && outranks(cand, run_task)) begin
            ready_rec[best] = run_task;
            run_task = cand;
            preemptions++;
          end
        end else begin
          ready_used[best] = 1'b0;
          run_task   = cand;
          run_active = 1'b1;
        end
      end

      if (run_active) begin
        r.ran_valid = 1'b1;
        r.ran_id    = run_task.id;
        if (run_task.remaining != 16'd0) run_task.remaining--;
      end
      tick_now++;

      for (i = 0; i < DEPTH; i++) begin
        if (ready_used[i] && ready_rec[i].wait_cnt != pps_pkg::WAIT_MAX) begin
          ready_rec[i].wait_cnt++;
        end
      end

      // Completion report and totals.
      if (run_active && run_task.remaining == 16'd0) begin
        r.done_res        = 1'b1;
        r.done_wait       = run_task.wait_cnt;
        r.done_turnaround = {1'b0, run_task.wait_cnt} + {1'b0, run_task.burst};
        wait_sum = add_clamped(wait_sum, {16'd0, run_task.wait_cnt});
        turn_sum = add_clamped(turn_sum, {15'd0, r.done_turnaround});
        if (tasks_finished != pps_pkg::COUNT_MAX) tasks_finished++;
        run_active = 1'b0;
      end
    end
    r.sum_wait       = wait_sum;
    r.sum_turnaround = turn_sum;
    r.finished_count = tasks_finished;
    r.now_time       = tick_now;
    return r;
  endfunction

  function automatic pps_pkg::in_word_t add_word(input logic [7:0] id, input logic [15:0] burst,
                                                 input logic [7:0] prio);
    pps_pkg::in_word_t w;
    w.cmd        = pps_pkg::CMD_ADD;
    w.task_id    = id;
    w.burst_len  = burst;
    w.prio_level = prio;
    return w;
  endfunction

  function automatic pps_pkg::in_word_t tick_word();
    pps_pkg::in_word_t w;
    w     = '0;
    w.cmd = pps_pkg::CMD_TICK;
    return w;
  endfunction

  // Send one word: called and returning at a falling edge. Start stays high
  // into the next word unless the sender decides to idle for a while.
  task automatic send_word(input pps_pkg::in_word_t w);
    int gap;
    in_word <= w;
    start   <= 1'b1;
    do @(posedge clk); while (busy);
    expected_results.insert(expected_results.size(), schedule_step(w));
    words_sent++;
    @(negedge clk);
    if ($urandom_range(99) < sender_idle_pct) begin
      gap = $urandom_range(1, 2 * (DEPTH + 2));
      start <= 1'b0;
      repeat (gap) @(negedge clk);
    end
  endtask

  task automatic check_field(input string name, input logic [31:0] exp_v,
                             input logic [31:0] act_v);
    if (act_v !== exp_v) begin
      $error("%s: expected %0d, got %0d", name, exp_v, act_v);
      mismatches++;
    end
  endtask

  // Compare every strobed result word with the oldest prediction.
  always @(posedge clk) begin : result_check
    pps_pkg::out_word_t exp_w;
    if (rst_n && out_strobe) begin
      if (expected_results.size() == 0) begin
        $error("result word arrived with no prediction pending");
        mismatches++;
      end else begin
        exp_w = expected_results.pop_front();
        check_field("add_rejected", exp_w.add_rejected, out_word.add_rejected);
        check_field("ran_valid", exp_w.ran_valid, out_word.ran_valid);
        check_field("ran_id", exp_w.ran_id, out_word.ran_id);
        check_field("done_res", exp_w.done_res, out_word.done_res);
        check_field("done_wait", exp_w.done_wait, out_word.done_wait);
        check_field("done_turnaround", exp_w.done_turnaround, out_word.done_turnaround);
        check_field("sum_wait", exp_w.sum_wait, out_word.sum_wait);
        check_field("sum_turnaround", exp_w.sum_turnaround, out_word.sum_turnaround);
        check_field("finished_count", exp_w.finished_count, out_word.finished_count);
        check_field("now_time", exp_w.now_time, out_word.now_time);
      end
    end
  end

  // Watchdog against a hung handshake.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  // A tick with nothing ready and nothing running only advances time.
  task automatic test_idle_tick();
    send_word(tick_word());
  endtask

  // A zero-length task ranks behind a live one, then finishes on the tick
  // that picks it.
  task automatic test_zero_burst();
    send_word(add_word(8'h00, 16'd0, 8'd0));
    send_word(add_word(8'h11, 16'd2, 8'd9));
    send_word(tick_word());
    send_word(tick_word());
    send_word(tick_word());
  endtask

  // Equal priority does not preempt; a strictly lower value does, and the
  // displaced task later resumes ahead of a newer one of the same priority.
  task automatic test_preemption();
    send_word(add_word(8'h20, 16'd4, 8'd50));
    send_word(tick_word());
    send_word(add_word(8'h21, 16'd2, 8'd50));
    send_word(tick_word());
    send_word(add_word(8'h22, 16'd1, 8'd49));
    send_word(tick_word());
    send_word(tick_word());
  endtask

  // Same priority and arrival: the shorter remainder wins, and a full tie
  // goes to the lower slot.
  task automatic test_tie_break();
    send_word(add_word(8'h30, 16'd5, 8'd1));
    send_word(add_word(8'h31, 16'd3, 8'd1));
    send_word(add_word(8'h32, 16'd3, 8'd1));
    send_word(add_word(8'h33, 16'd3, 8'd1));
    send_word(tick_word());
    send_word(tick_word());
    send_word(tick_word());
  endtask

  // All-ones fields. This task never finishes, so it sits behind every
  // other priority for the rest of the run.
  task automatic test_field_extremes();
    send_word(add_word(8'hFF, 16'hFFFF, 8'hFF));
    send_word(tick_word());
  endtask

  // Fill every free slot, then two adds that must be rejected.
  task automatic test_table_full();
    int used;
    int i;
    used = 0;
    for (i = 0; i < DEPTH; i++) begin
      if (ready_used[i]) used++;
    end
    for (i = used; i < DEPTH; i++) begin
      send_word(add_word(8'h40 + 8'(i), 16'(i % 5 + 1), 8'(i % 4)));
    end
    send_word(add_word(8'hEE, 16'd2, 8'd0));
    send_word(add_word(8'hEF, 16'd1, 8'd0));
  endtask

  // Random adds and ticks. The add share changes every forty words so the
  // table alternates between filling up and draining. Priorities cluster at
  // small values to force ties; the top value is kept for the long task.
  task automatic test_random_traffic(input int n_words, input int idle_pct);
    pps_pkg::in_word_t w;
    int                add_pct;
    int                k;
    sender_idle_pct = idle_pct;
    add_pct = 20;
    for (k = 0; k < n_words; k++) begin
      if (k % 40 == 0) begin
        case ($urandom_range(2))
          0: add_pct = 10;
          1: add_pct = 20;
          default: add_pct = 35;
        endcase
      end
      w.cmd     = ($urandom_range(99) < add_pct) ? pps_pkg::CMD_ADD : pps_pkg::CMD_TICK;
      w.task_id = 8'($urandom_range(255));
      if ($urandom_range(99) < 4) begin
        w.burst_len = 16'($urandom_range(7, 40));
      end else begin
        w.burst_len = 16'($urandom_range(1, 6));
      end
      if ($urandom_range(99) < 60) begin
        w.prio_level = 8'($urandom_range(3));
      end else begin
        w.prio_level = 8'($urandom_range(254));
      end
      send_word(w);
    end
  endtask

  initial begin
    clear_schedule_state();
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    sender_idle_pct = 32;
    test_idle_tick();
    test_zero_burst();
    test_preemption();
    test_tie_break();
    test_field_extremes();
    test_table_full();
    test_random_traffic(RANDOM_WORDS, 32);
    test_random_traffic(RANDOM_WORDS, 46);
    test_random_traffic(RANDOM_WORDS, 0);
    start <= 1'b0;

    // Let the last result words come out, then watch for strays.
    while (expected_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Covered %0d words: %0d ticks, %0d adds, %0d adds turned away by a full table.",
             words_sent, ticks_sent, adds_sent, adds_rejected);
    $display("Tasks preempted %0d times, %0d completed, time stood at %0d.",
             preemptions, tasks_finished, tick_now);
    if (mismatches == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
